[sv/sfb_pkg.sv]
// ============================================================================
// Flit send buffer package
// Shared constants, flit field helpers and the types that pass between the
// queue, the core and the top level.
// ============================================================================
package sfb_pkg;

    // Queue depth and flit geometry.
    localparam int QUEUE_DEPTH  = 4;
    localparam int PAYLOAD_BITS = 32;
    localparam int FLIT_W       = PAYLOAD_BITS + 18;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int DEST_W       = 18;
    localparam int COORD_W      = 4;

    // Header field positions inside a flit.
    localparam int HDR_LO  = PAYLOAD_BITS;
    localparam int Y_LO    = PAYLOAD_BITS + 8;
    localparam int X_LO    = PAYLOAD_BITS + 12;
    localparam int MC_BIT  = PAYLOAD_BITS + 16;
    localparam int EOP_BIT = PAYLOAD_BITS + 17;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_W        = 3 * 1 + 2 * (FLIT_W + 1);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 7 + 2 * FLIT_W + DEST_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd3;

    // Local sender phases.
    typedef enum logic [1:0] {
        LP_IDLE = 2'd0,
        LP_ARB  = 2'd1,
        LP_SEND = 2'd2
    } t_lphase;

    typedef logic [FLIT_W-1:0] t_flit;

    typedef struct packed {
        logic [COORD_W-1:0] own_x;
        logic [COORD_W-1:0] own_y;
        logic [COORD_W-1:0] grid_cols;
        logic [COORD_W-1:0] grid_rows;
    } t_cfg;

    // One input item; members are listed from the highest bit down so that
    // fetch_valid lands in bit 0.
    typedef struct packed {
        logic  global_ack;
        logic  local_ack;
        logic  grant;
        t_flit data_flit;
        logic  data_valid;
        t_flit fetch_flit;
        logic  fetch_valid;
    } t_step_in;

    // One result item; fetch_accept lands in bit 0.
    typedef struct packed {
        logic              out_of_grid;
        logic              buffers_full;
        logic [DEST_W-1:0] arb_destination;
        logic              arb_request;
        t_flit             global_out_flit;
        logic              global_out_valid;
        t_flit             local_out_flit;
        logic              local_out_valid;
        logic              data_accept;
        logic              fetch_accept;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    function automatic logic [COORD_W-1:0] flit_x(input t_flit f);
        return f[X_LO +: COORD_W];
    endfunction

    function automatic logic [COORD_W-1:0] flit_y(input t_flit f);
        return f[Y_LO +: COORD_W];
    endfunction

    function automatic logic [DEST_W-1:0] flit_dest(input t_flit f);
        return {1'b0, f[MC_BIT:HDR_LO]};
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

[sv/sfb_fifo.sv]
// ============================================================================
// Flit queue
// A queue of flits held in a synchronous memory. The next head entry is read
// ahead into a register, with the write data forwarded when the entry
// being read is written in the same cycle.
// ============================================================================
module sfb_fifo
    import sfb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fifo_ctl        i_ctl,
    input  t_flit            i_wdata,
    output t_flit            o_head,
    output logic [CNT_W-1:0] o_count
);

    t_flit            r_mem [QUEUE_DEPTH];
    t_flit            r_head_data;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] r_tail;
    logic [PTR_W-1:0] n_tail;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Pointer and fill count update.
    always_comb begin
        n_head  = i_ctl.pop  ? ptr_inc(r_head) : r_head;
        n_tail  = i_ctl.push ? ptr_inc(r_tail) : r_tail;
        n_count = r_count + CNT_W'(i_ctl.push) - CNT_W'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

    // Registered read of the next head entry, forwarding a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (r_tail == n_head)) begin
            r_head_data <= i_wdata;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_head  = r_head_data;
    assign o_count = r_count;

endmodule

[sv/sfb_core.sv]
// ============================================================================
// Flit send buffer core
// Receiver, local sender with arbitration and global sender around the two
// flit queues. State advances by one step for each accepted item.
// ============================================================================
module sfb_core
    import sfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_step_in i_step,
    input  t_cfg     i_cfg,
    output t_result  o_res
);

    t_lphase           r_phase;
    t_lphase           n_phase;
    logic              r_lock;
    logic              n_lock;
    logic              r_held;
    logic              n_held;
    logic [DEST_W-1:0] r_dest;
    logic [DEST_W-1:0] n_dest;
    logic              r_last_eop;
    logic              n_last_eop;
    logic              r_gwait;
    logic              n_gwait;
    t_flit             r_lreg;
    t_flit             n_lreg;
    t_flit             r_greg;
    t_flit             n_greg;

    t_flit             l_head;
    t_flit             g_head;
    logic [CNT_W-1:0]  l_count;
    logic [CNT_W-1:0]  g_count;
    t_fifo_ctl         l_ctl;
    t_fifo_ctl         g_ctl;

    logic              full;
    logic              l_pop;
    logic              g_pop;
    logic              take_fetch;
    logic              take_data;
    logic              to_local;
    logic              oog;
    t_flit             sel_flit;
    logic [COORD_W-1:0] sel_x;
    logic [COORD_W-1:0] sel_y;

    // Local sender: arbitrate, send, wait for ack.
    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_dest     = r_dest;
        n_lreg     = r_lreg;
        n_last_eop = r_last_eop;
        l_pop      = 1'b0;
        unique case (r_phase)
            LP_SEND: begin
                if (i_step.local_ack) begin
                    n_phase = LP_IDLE;
                end
            end
            LP_ARB: begin
                if (i_step.grant && (l_count != '0)) begin
                    l_pop      = 1'b1;
                    n_lreg     = l_head;
                    n_last_eop = l_head[EOP_BIT];
                    n_phase    = LP_SEND;
                end
            end
            LP_IDLE: begin
                if (r_last_eop) begin
                    n_held = 1'b0;
                end
                if (l_count != '0) begin
                    n_held  = 1'b1;
                    n_dest  = flit_dest(l_head);
                    n_phase = LP_ARB;
                end
            end
            default: begin
                n_phase = LP_IDLE;
            end
        endcase
    end

    // Global sender: present the head flit and wait for ack.
    always_comb begin
        n_gwait = r_gwait;
        n_greg  = r_greg;
        g_pop   = 1'b0;
        if (r_gwait) begin
            if (i_step.global_ack) begin
                n_gwait = 1'b0;
            end
        end else if (g_count != '0) begin
            g_pop   = 1'b1;
            n_greg  = g_head;
            n_gwait = 1'b1;
        end
    end

    // Receiver: pick a port, route the flit, track the packet lock.
    always_comb begin
        full       = (l_count == CNT_W'(QUEUE_DEPTH)) || (g_count == CNT_W'(QUEUE_DEPTH));
        take_fetch = !full && !r_lock && i_step.fetch_valid;
        take_data  = !full && !take_fetch && i_step.data_valid;
        sel_flit   = take_fetch ? i_step.fetch_flit : i_step.data_flit;
        sel_x      = flit_x(sel_flit);
        sel_y      = flit_y(sel_flit);
        to_local   = sel_flit[MC_BIT] || ((sel_x == i_cfg.own_x) && (sel_y == i_cfg.own_y));
        oog        = (take_fetch || take_data) && !to_local &&
                     ((sel_x < COORD_W'(1)) || (sel_y < COORD_W'(1)) ||
                      (sel_x > i_cfg.grid_cols) || (sel_y > i_cfg.grid_rows));
        n_lock     = (take_fetch || take_data) ? !sel_flit[EOP_BIT] : r_lock;
    end

    // Queue controls act only on accepted items.
    always_comb begin
        l_ctl.push = i_en && (take_fetch || take_data) && to_local;
        l_ctl.pop  = i_en && l_pop;
        g_ctl.push = i_en && (take_fetch || take_data) && !to_local;
        g_ctl.pop  = i_en && g_pop;
    end

    sfb_fifo u_local_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (l_ctl),
        .i_wdata (sel_flit),
        .o_head  (l_head),
        .o_count (l_count)
    );

    sfb_fifo u_global_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (g_ctl),
        .i_wdata (sel_flit),
        .o_head  (g_head),
        .o_count (g_count)
    );

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= LP_IDLE;
            r_lock     <= 1'b0;
            r_held     <= 1'b0;
            r_dest     <= '0;
            r_last_eop <= 1'b0;
            r_gwait    <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_lock     <= n_lock;
            r_held     <= n_held;
            r_dest     <= n_dest;
            r_last_eop <= n_last_eop;
            r_gwait    <= n_gwait;
        end
    end

    // Output flit registers; only shown while their valid is set.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lreg <= n_lreg;
            r_greg <= n_greg;
        end
    end

    // Result of this step, taken from the updated state.
    always_comb begin
        o_res.fetch_accept     = take_fetch;
        o_res.data_accept      = take_data;
        o_res.local_out_valid  = (n_phase == LP_SEND);
        o_res.local_out_flit   = (n_phase == LP_SEND) ? n_lreg : '0;
        o_res.global_out_valid = n_gwait;
        o_res.global_out_flit  = n_gwait ? n_greg : '0;
        o_res.arb_request      = n_held;
        o_res.arb_destination  = n_dest;
        o_res.buffers_full     = full;
        o_res.out_of_grid      = oog;
    end

endmodule

[sv/flit_send_buffer_with_arbitration.sv]
// ============================================================================
// Flit send buffer with arbitration
// A result item appears on the output register in the cycle after its input
// item is accepted. One item per cycle while the output register is free or
// being drained, set by the queue state update around the registered head read.
// Reset: synchronous, active low; clears the sender, lock and queue counters
// and loads the configuration defaults. Queue memories are not cleared.
// ============================================================================
module flit_send_buffer_with_arbitration
    import sfb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input item stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // Bits from low up: fetch_valid, fetch_flit, data_valid, data_flit,
    // grant, local_ack, global_ack, zero fill.
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result item stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // Bits from low up: fetch_accept, data_accept, local_out_valid,
    // local_out_flit, global_out_valid, global_out_flit, arb_request,
    // arb_destination, buffers_full, out_of_grid, zero fill.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_W-1:0]     i_cfg_data
);

    t_cfg                   r_cfg;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   in_accept;
    t_step_in               step;
    t_result                res;

    // Input is taken whenever the output register is free or being drained.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign step            = t_step_in'(i_s_axis_tdata[IN_W-1:0]);

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_x     <= COORD_W'(1);
            r_cfg.own_y     <= COORD_W'(1);
            r_cfg.grid_cols <= COORD_W'(4);
            r_cfg.grid_rows <= COORD_W'(4);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_X:     r_cfg.own_x     <= i_cfg_data;
                CFG_OWN_Y:     r_cfg.own_y     <= i_cfg_data;
                CFG_GRID_COLS: r_cfg.grid_cols <= i_cfg_data;
                CFG_GRID_ROWS: r_cfg.grid_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_accept),
        .i_step  (step),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= {{(OUT_TDATA_W - OUT_W){1'b0}}, res};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // An accepted item always leaves a result in the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item left no result");

    // Only one port is ever taken in a step.
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]))
        else $error("both ports accepted in one step");

    // A flit on the local output is always covered by the arbitration request.
    a_send_holds_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[2]) |-> r_out_data[3 + 2 * FLIT_W + 1])
        else $error("local flit sent without request");

    // No port is taken while the queues report full.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[OUT_W - 2]) |-> !(r_out_data[0] || r_out_data[1]))
        else $error("flit taken while buffers full");

endmodule
